// File: rtl/core/fcsg_pkg.sv
// Package for the filled circle span generator.
// Holds the shared types, widths and the walk sequencer state codes.
// No dependencies.
package fcsg_pkg;

	localparam int MAX_RADIUS = 15;
	localparam int COORD_W    = 13;
	localparam int OFS_W      = 7;
	localparam int DIFF_W     = 9;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [OFS_W-1:0]   ofs_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_EMIT
	} walk_state_t;

	// Order of the four spans of one walk step
	typedef enum logic [1:0] {
		PH_ROW_POS_OX,
		PH_ROW_POS_OY,
		PH_ROW_NEG_OY,
		PH_ROW_NEG_OX
	} phase_t;

	typedef struct packed {
		logic   idle;
		logic   emit;
		phase_t phase;
		ofs_t   ox;
		ofs_t   oy;
		logic   last;
	} walk_t;

endpackage

// File: rtl/core/fcsg_walk.sv
// Circle walk sequencer with one shared update unit for the error term.
// Steps the two offsets and walks the four span phases of each step.
// Depends on fcsg_pkg.
module fcsg_walk #(
	parameter int MaxRadius = fcsg_pkg::MAX_RADIUS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [3:0]     radius,
	input  logic           take,
	output fcsg_pkg::walk_t ctl
);
	import fcsg_pkg::*;

	localparam int GuardW = $clog2(MaxRadius + 2);

	walk_state_t       state_q, state_d;
	phase_t            phase_q;
	ofs_t              ox_q, oy_q, nox_q, noy_q;
	diff_t             d_q, nd_q;
	logic [GuardW-1:0] guard_q, nguard_q;
	logic [3:0]        rad_q;
	logic              done_q;

	logic [3:0]        rad_sat;
	diff_t             ox9, oy9, rad9, two_ox, lim, upd_d;
	ofs_t              upd_ox, upd_oy;
	logic [GuardW-1:0] upd_guard;
	logic              ge_ox, lt_lim, cont;

	assign rad_sat = (radius > 4'(MaxRadius)) ? 4'(MaxRadius) : radius;

	// Shared update unit: one walk step of the error term
	always_comb begin
		ox9    = {{(DIFF_W-OFS_W){ox_q[OFS_W-1]}}, ox_q};
		oy9    = {{(DIFF_W-OFS_W){oy_q[OFS_W-1]}}, oy_q};
		rad9   = {{(DIFF_W-4){1'b0}}, rad_q};
		two_ox = ox9 <<< 1;
		lim    = (rad9 - oy9) <<< 1;
		ge_ox  = (d_q >= two_ox);
		lt_lim = (d_q < lim);
		upd_ox = ox_q;
		upd_oy = oy_q;
		if (ge_ox) begin
			upd_d  = d_q - two_ox - diff_t'(1);
			upd_ox = ox_q + ofs_t'(1);
		end else if (lt_lim) begin
			upd_d  = d_q + (oy9 <<< 1) - diff_t'(1);
			upd_oy = oy_q - ofs_t'(1);
		end else begin
			upd_d  = d_q + ((oy9 - ox9 - diff_t'(1)) <<< 1);
			upd_oy = oy_q - ofs_t'(1);
			upd_ox = ox_q + ofs_t'(1);
		end
		upd_guard = guard_q + GuardW'(1);
		cont      = (upd_guard <= GuardW'(MaxRadius)) && (upd_oy >= upd_ox);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl.idle  = 1'b0;
		ctl.emit  = 1'b0;
		ctl.phase = phase_q;
		ctl.ox    = ox_q;
		ctl.oy    = oy_q;
		ctl.last  = done_q && (phase_q == PH_ROW_NEG_OX);
		case (state_q)
			ST_IDLE: begin
				ctl.idle = 1'b1;
				if (start) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				ctl.emit = 1'b1;
				if (take && phase_q == PH_ROW_NEG_OX) begin
					state_d = done_q ? ST_IDLE : ST_UPDATE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_ROW_POS_OX;
			done_q   <= 1'b0;
			guard_q  <= '0;
			nguard_q <= '0;
		end else begin
			if (start && state_q == ST_IDLE) begin
				guard_q <= '0;
			end else if (state_q == ST_UPDATE) begin
				nguard_q <= upd_guard;
				done_q   <= !cont;
				phase_q  <= PH_ROW_POS_OX;
			end else if (state_q == ST_EMIT && take) begin
				if (phase_q == PH_ROW_NEG_OX) begin
					guard_q <= nguard_q;
				end else begin
					phase_q <= phase_t'(phase_q + 2'd1);
				end
			end
		end
	end

	// Walk datapath; hold the next step aside until the current spans are out
	always_ff @(posedge clk) begin
		if (start && state_q == ST_IDLE) begin
			rad_q <= rad_sat;
			ox_q  <= '0;
			oy_q  <= {{(OFS_W-4){1'b0}}, rad_sat};
			d_q   <= {{(DIFF_W-4){1'b0}}, rad_sat} - diff_t'(1);
		end else if (state_q == ST_UPDATE) begin
			nox_q <= upd_ox;
			noy_q <= upd_oy;
			nd_q  <= upd_d;
		end else if (state_q == ST_EMIT && take && phase_q == PH_ROW_NEG_OX) begin
			ox_q <= nox_q;
			oy_q <= noy_q;
			d_q  <= nd_q;
		end
	end

endmodule

// File: rtl/core/filled_circle_span_generator.sv
// Filled circle span generator, top level.
// Latches one circle, runs the walk sequencer and registers each span.
// Depends on fcsg_pkg and fcsg_walk.
//
// Usage:
//   The circle channel (circle_valid/circle_ready) takes one circle: center,
//   radius (saturated to MaxRadius) and packed ARGB color. The span channel
//   (span_valid/span_ready) returns the horizontal spans that fill it, four
//   per walk step, with last_span set on the final one.
//   circle_ready is high only while the sequencer is idle; one circle is in
//   work at a time.
//   The first span goes from the idle state through the error-term update
//   state to the emit state, which loads it into the output register.
//   Each walk step runs once through the error-term update unit and then
//   emits its four spans, one per cycle while span_ready does not stall; a
//   circle walks s steps (s <= radius + 1).
//   A radius-15 circle walks 11 steps: 44 spans.
//   The next circle is taken while the last span still waits in the output
//   register; the color bytes travel with each span.
//   A stall on span_ready holds the output register and the walk in place.
//   Reset clears the sequencer and the output valid; no span is pending.
module filled_circle_span_generator #(
	parameter int MaxRadius = fcsg_pkg::MAX_RADIUS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  circle_valid,
	output logic                  circle_ready,
	input  logic [10:0]           center_x,
	input  logic [10:0]           center_y,
	input  logic [3:0]            radius,
	input  logic [31:0]           color,
	output logic                  span_valid,
	input  logic                  span_ready,
	output fcsg_pkg::coord_t      span_left,
	output fcsg_pkg::coord_t      span_right,
	output fcsg_pkg::coord_t      span_row,
	output logic [7:0]            red,
	output logic [7:0]            green,
	output logic [7:0]            blue,
	output logic [7:0]            alpha,
	output logic                  last_span
);
	import fcsg_pkg::*;

	walk_t       ctl;
	logic        start, take;
	logic [10:0] cx_q, cy_q;
	logic [31:0] color_q;
	logic [31:0] argb_q;
	logic        span_valid_q;
	coord_t      left_q, right_q, row_q;
	logic        last_q;

	coord_t      cx_c, cy_c, ox_c, oy_c, xofs, left_c, right_c, row_c;

	assign circle_ready = ctl.idle;
	assign start        = circle_valid && ctl.idle;
	assign take         = ctl.emit && (!span_valid_q || span_ready);

	fcsg_walk #(
		.MaxRadius (MaxRadius)
	) u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.radius (radius),
		.take   (take),
		.ctl    (ctl)
	);

	always_ff @(posedge clk) begin
		if (start) begin
			cx_q    <= center_x;
			cy_q    <= center_y;
			color_q <= color;
		end
	end

	always_comb begin
		cx_c = {{(COORD_W-11){1'b0}}, cx_q};
		cy_c = {{(COORD_W-11){1'b0}}, cy_q};
		ox_c = {{(COORD_W-OFS_W){ctl.ox[OFS_W-1]}}, ctl.ox};
		oy_c = {{(COORD_W-OFS_W){ctl.oy[OFS_W-1]}}, ctl.oy};
		case (ctl.phase)
			PH_ROW_POS_OX: begin
				xofs  = oy_c;
				row_c = cy_c + ox_c;
			end
			PH_ROW_POS_OY: begin
				xofs  = ox_c;
				row_c = cy_c + oy_c;
			end
			PH_ROW_NEG_OY: begin
				xofs  = ox_c;
				row_c = cy_c - oy_c;
			end
			PH_ROW_NEG_OX: begin
				xofs  = oy_c;
				row_c = cy_c - ox_c;
			end
			default: begin
				xofs  = oy_c;
				row_c = cy_c;
			end
		endcase
		left_c  = cx_c - xofs;
		right_c = cx_c + xofs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_valid_q <= 1'b0;
		end else if (take) begin
			span_valid_q <= 1'b1;
		end else if (span_ready) begin
			span_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			left_q  <= left_c;
			right_q <= right_c;
			row_q   <= row_c;
			last_q  <= ctl.last;
			argb_q  <= color_q;
		end
	end

	assign span_valid = span_valid_q;
	assign span_left  = left_q;
	assign span_right = right_q;
	assign span_row   = row_q;
	assign last_span  = last_q;
	assign alpha      = argb_q[31:24];
	assign red        = argb_q[23:16];
	assign green      = argb_q[15:8];
	assign blue       = argb_q[7:0];

endmodule

// File: rtl/core/fcsg_checker.sv
// Port-level checks for the filled circle span generator.
// Bound to the top level; depends on fcsg_pkg.
// Sees only the top-level ports.
module fcsg_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             circle_valid,
	input logic             circle_ready,
	input logic [10:0]      center_x,
	input logic [10:0]      center_y,
	input logic [3:0]       radius,
	input logic [31:0]      color,
	input logic             span_valid,
	input logic             span_ready,
	input fcsg_pkg::coord_t span_left,
	input fcsg_pkg::coord_t span_right,
	input fcsg_pkg::coord_t span_row,
	input logic [7:0]       red,
	input logic [7:0]       green,
	input logic [7:0]       blue,
	input logic [7:0]       alpha,
	input logic             last_span
);

	// Stalled span holds
	a_span_hold: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid && !span_ready |=> span_valid && $stable(span_left)
			&& $stable(span_right) && $stable(span_row))
		else $error("stalled span changed");

	// One circle in work at a time
	a_one_circle: assert property (@(posedge clk) disable iff (!arst_n)
		circle_valid && circle_ready |=> !circle_ready)
		else $error("circle taken while busy");

	// Spans never run backward
	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid |-> span_left <= span_right)
		else $error("span left above right");

	// A circle is not finished before its last span
	a_no_early_ready: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid && !last_span |-> !circle_ready)
		else $error("ready before last span");

endmodule

bind filled_circle_span_generator fcsg_checker u_fcsg_checker (.*);

// File: tb/tb_filled_circle_span_generator.sv
// Testbench for filled_circle_span_generator: drives circle requests, predicts the spans
// of each accepted circle and checks them in order against the span channel.
// Depends on fcsg_pkg and the filled_circle_span_generator RTL.
module tb_filled_circle_span_generator;
	import fcsg_pkg::*;

	localparam int IDLE_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_CIRCLES = 215;

	typedef struct {
		logic [10:0] cx;
		logic [10:0] cy;
		logic [3:0]  rad;
		logic [31:0] argb;
	} circle_t;

	typedef struct {
		coord_t     left;
		coord_t     right;
		coord_t     row;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last;
	} span_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        circle_valid = 1'b0;
	logic        circle_ready;
	logic [10:0] center_x = '0;
	logic [10:0] center_y = '0;
	logic [3:0]  radius = '0;
	logic [31:0] color = '0;
	logic        span_valid;
	logic        span_ready = 1'b0;
	coord_t      span_left;
	coord_t      span_right;
	coord_t      span_row;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic        last_span;

	circle_t circle_q[$];
	span_t   span_q[$];
	int      mismatches = 0;
	int      idle_cycles = 0;
	int      burst_left = 1;
	int      gap_left = 0;
	int      stall_left = 0;
	int      stall_mode = 0;
	int      mode_cycles = 0;

	filled_circle_span_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.circle_valid(circle_valid),
		.circle_ready(circle_ready),
		.center_x(center_x),
		.center_y(center_y),
		.radius(radius),
		.color(color),
		.span_valid(span_valid),
		.span_ready(span_ready),
		.span_left(span_left),
		.span_right(span_right),
		.span_row(span_row),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.last_span(last_span)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic span_t make_span(int l, int r, int row, logic [31:0] argb, logic last);
		span_t s;
		s.left  = l[12:0];
		s.right = r[12:0];
		s.row   = row[12:0];
		s.red   = argb[23:16];
		s.green = argb[15:8];
		s.blue  = argb[7:0];
		s.alpha = argb[31:24];
		s.last  = last;
		return s;
	endfunction

	// Walk the circle and append its spans, four per step, to the expected queue.
	task automatic queue_circle_spans(circle_t c);
		int x;
		int y;
		int rad;
		int ox;
		int oy;
		int d;
		int px;
		int py;
		int step;
		logic fin;
		x = c.cx;
		y = c.cy;
		rad = (c.rad > MAX_RADIUS) ? MAX_RADIUS : c.rad;
		ox = 0;
		oy = rad;
		d = rad - 1;
		for (step = 0; step <= MAX_RADIUS && oy >= ox; step++) begin
			px = ox;
			py = oy;
			if (d >= 2 * ox) begin
				d -= 2 * ox + 1;
				ox += 1;
			end else if (d < 2 * (rad - oy)) begin
				d += 2 * oy - 1;
				oy -= 1;
			end else begin
				d += 2 * (oy - ox - 1);
				oy -= 1;
				ox += 1;
			end
			fin = (step == MAX_RADIUS) || (oy < ox);
			span_q.push_back(make_span(x - py, x + py, y + px, c.argb, 1'b0));
			span_q.push_back(make_span(x - px, x + px, y + py, c.argb, 1'b0));
			span_q.push_back(make_span(x - px, x + px, y - py, c.argb, 1'b0));
			span_q.push_back(make_span(x - py, x + py, y - px, c.argb, fin));
		end
	endtask

	function automatic logic [10:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return 11'($urandom_range(0, 20));
			1: return 11'($urandom_range(2027, 2047));
			default: return 11'($urandom_range(0, 2047));
		endcase
	endfunction

	task automatic add_circle(int x, int y, int r, logic [31:0] argb);
		circle_t c;
		c.cx = x[10:0];
		c.cy = y[10:0];
		c.rad = r[3:0];
		c.argb = argb;
		circle_q.push_back(c);
	endtask

	// Request driver: bursts of circles separated by random gaps.
	always @(posedge clk) begin
		circle_t c;
		if (arst_n) begin
			if (circle_valid && circle_ready) begin
				c.cx = center_x;
				c.cy = center_y;
				c.rad = radius;
				c.argb = color;
				queue_circle_spans(c);
			end
			if (!circle_valid || circle_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					circle_valid <= 1'b0;
				end else if (circle_q.size() > 0) begin
					c = circle_q.pop_front();
					center_x <= c.cx;
					center_y <= c.cy;
					radius <= c.rad;
					color <= c.argb;
					circle_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 8);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					circle_valid <= 1'b0;
				end
			end
		end
	end

	// Span receiver: the stall mode is redrawn when its countdown runs out; mode 0 starts no new stalls.
	always @(posedge clk) begin
		if (mode_cycles == 0) begin
			stall_mode <= $urandom_range(0, 3);
			mode_cycles <= 64;
		end else begin
			mode_cycles <= mode_cycles - 1;
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			span_ready <= 1'b0;
		end else if (stall_mode != 0 && $urandom_range(0, 7) < 2 * stall_mode) begin
			stall_left <= $urandom_range(0, 4 * stall_mode - 1);
			span_ready <= 1'b0;
		end else begin
			span_ready <= 1'b1;
		end
	end

	// Span monitor
	always @(posedge clk) begin
		span_t got;
		span_t want;
		if (arst_n && span_valid && span_ready) begin
			got.left  = span_left;
			got.right = span_right;
			got.row   = span_row;
			got.red   = red;
			got.green = green;
			got.blue  = blue;
			got.alpha = alpha;
			got.last  = last_span;
			if (span_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected span: left %0d right %0d row %0d last %0b",
						got.left, got.right, got.row, got.last);
			end else begin
				want = span_q.pop_front();
				if (got.left !== want.left || got.right !== want.right ||
						got.row !== want.row || got.red !== want.red ||
						got.green !== want.green || got.blue !== want.blue ||
						got.alpha !== want.alpha || got.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"span mismatch: expected left %0d right %0d row %0d ",
							"argb %02h%02h%02h%02h last %0b, got left %0d right %0d row %0d ",
							"argb %02h%02h%02h%02h last %0b"},
							want.left, want.right, want.row, want.alpha, want.red,
							want.green, want.blue, want.last, got.left, got.right, got.row,
							got.alpha, got.red, got.green, got.blue, got.last);
				end
			end
		end
	end

	// Watchdog: cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((circle_valid && circle_ready) || (span_valid && span_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		// Edge centers, both radius extremes and color byte extremes
		add_circle(0, 0, 0, 32'h0000_0000);
		add_circle(2047, 2047, 15, 32'hFFFF_FFFF);
		add_circle(0, 0, 15, 32'h8000_0000);
		add_circle(2047, 0, 15, 32'h00FF_0000);
		add_circle(0, 2047, 15, 32'h0000_FF00);
		add_circle(1024, 1024, 0, 32'h0000_00FF);
		add_circle(2047, 2047, 0, 32'hFF00_0000);
		add_circle(15, 15, 15, 32'hA5A5_5A5A);
		add_circle(2032, 2032, 15, 32'h5A5A_A5A5);
		add_circle(1, 1, 1, 32'h0102_0304);
		add_circle(2046, 3, 2, 32'h7F80_01FE);
		add_circle(100, 200, 3, 32'hDEAD_BEEF);
		add_circle(7, 2040, 7, 32'h1234_5678);
		add_circle(1365, 682, 8, 32'hFEDC_BA98);
		add_circle(682, 1365, 14, 32'h0F0F_F0F0);
		for (int i = 0; i < RANDOM_CIRCLES; i++)
			add_circle(rand_coord(), rand_coord(), $urandom_range(0, 15), $urandom());

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// Sample between edges so the driver and monitor updates have settled
		while (circle_q.size() > 0 || circle_valid)
			@(negedge clk);
		while (span_q.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && span_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
